@@ sv/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character constants and byte sequencing functions shared by the
// front classifier, the descriptor queue and the output sequencer.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_RAW,
    K_ESC2,
    K_UHEX,
    K_U202X
  } kind_t;

  // pre/post: number of held prefix bytes (E2, then 80) released around the body
  typedef struct packed {
    logic [1:0] pre;
    kind_t      kind;
    logic [7:0] arg;
    logic [1:0] post;
    logic       last;
  } desc_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] BY_BS    = 8'h08;
  localparam logic [7:0] BY_FF    = 8'h0C;
  localparam logic [7:0] BY_LF    = 8'h0A;
  localparam logic [7:0] BY_CR    = 8'h0D;
  localparam logic [7:0] BY_TAB   = 8'h09;
  localparam logic [7:0] BY_CTRL  = 8'h20;
  localparam logic [7:0] BY_LEAD  = 8'hE2;
  localparam logic [7:0] BY_MID   = 8'h80;
  localparam logic [7:0] BY_LS    = 8'hA8;
  localparam logic [7:0] BY_PS    = 8'hA9;

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) begin
      return CH_0 + {4'd0, n};
    end
    return 8'h37 + {4'd0, n};
  endfunction

  function automatic logic [2:0] body_len(kind_t k);
    logic [2:0] r;
    unique case (k)
      K_RAW:   r = 3'd1;
      K_ESC2:  r = 3'd2;
      K_UHEX:  r = 3'd6;
      K_U202X: r = 3'd6;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] desc_len(desc_t d);
    return {2'd0, d.pre} + {1'b0, body_len(d.kind)} + {2'd0, d.post};
  endfunction

  function automatic logic [7:0] prefix_byte(logic sel);
    return sel ? BY_MID : BY_LEAD;
  endfunction

  function automatic logic [7:0] body_byte(kind_t k, logic [7:0] arg, logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      K_RAW:  r = arg;
      K_ESC2: r = (pos == 3'd0) ? CH_BSL : arg;
      K_UHEX: begin
        case (pos) inside
          3'd0:       r = CH_BSL;
          3'd1:       r = CH_U;
          3'd2, 3'd3: r = CH_0;
          3'd4:       r = hex_char(arg[7:4]);
          default:    r = hex_char(arg[3:0]);
        endcase
      end
      K_U202X: begin
        case (pos) inside
          3'd0:       r = CH_BSL;
          3'd1:       r = CH_U;
          3'd2, 3'd4: r = CH_2;
          3'd3:       r = CH_0;
          default:    r = arg;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] desc_byte(desc_t d, logic [2:0] idx);
    logic [3:0] i;
    logic [3:0] j;
    logic [3:0] k;
    logic [3:0] blen;
    logic [7:0] r;
    i    = {1'b0, idx};
    blen = {1'b0, body_len(d.kind)};
    j    = i - {2'd0, d.pre};
    k    = j - blen;
    if (i < {2'd0, d.pre}) begin
      r = prefix_byte(idx[0]);
    end else if (j < blen) begin
      r = body_byte(d.kind, d.arg, j[2:0]);
    end else begin
      r = prefix_byte(k[0]);
    end
    return r;
  endfunction

endpackage

@@ sv/jse_front.sv @@
// ----------------------------------------------------------------------------
// jse_front
// Input classifier: tracks the held E2 / E2 80 prefix and turns each byte
// into a descriptor of the escaped bytes it causes.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  jse_pkg::in_item_t  item,
  output logic               q_push,
  output jse_pkg::desc_t     q_desc
);
  import jse_pkg::*;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_E2   = 2'd1;
  localparam logic [1:0] PH_E280 = 2'd2;

  logic [1:0] prefix;
  logic [1:0] prefix_next;
  logic [1:0] ph;
  logic [7:0] b;
  desc_t      d;

  always_comb begin
    b           = item.in_byte;
    ph          = (prefix == 2'd3) ? PH_NONE : prefix;
    d           = '0;
    d.kind      = K_NONE;
    prefix_next = PH_NONE;
    if (ph == PH_E2 && b == BY_MID) begin
      prefix_next = PH_E280;
    end else if (ph == PH_E280 && (b == BY_LS || b == BY_PS)) begin
      d.kind = K_U202X;
      d.arg  = (b == BY_LS) ? CH_8 : CH_9;
    end else begin
      d.pre = ph;
      unique case (b)
        CH_QUOTE: begin d.kind = K_ESC2; d.arg = CH_QUOTE; end
        CH_BSL:   begin d.kind = K_ESC2; d.arg = CH_BSL; end
        BY_BS:    begin d.kind = K_ESC2; d.arg = CH_B; end
        BY_FF:    begin d.kind = K_ESC2; d.arg = CH_F; end
        BY_LF:    begin d.kind = K_ESC2; d.arg = CH_N; end
        BY_CR:    begin d.kind = K_ESC2; d.arg = CH_R; end
        BY_TAB:   begin d.kind = K_ESC2; d.arg = CH_T; end
        BY_LEAD:  prefix_next = PH_E2;
        default: begin
          d.kind = (b < BY_CTRL) ? K_UHEX : K_RAW;
          d.arg  = b;
        end
      endcase
    end
    d.last = item.in_last;
    if (item.in_last) begin
      d.post      = prefix_next;
      prefix_next = PH_NONE;
    end
  end

  assign q_desc = d;
  assign q_push = take && (desc_len(d) != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= PH_NONE;
    end else if (take) begin
      prefix <= prefix_next;
    end
  end

endmodule

@@ sv/jse_queue.sv @@
// ----------------------------------------------------------------------------
// jse_queue
// Short descriptor queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module jse_queue #(
  parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  jse_pkg::desc_t  wr_desc,
  input  logic            rd,
  output jse_pkg::desc_t  head,
  output logic            full,
  output logic            has_data
);
  import jse_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == FULL_CNT);
  assign has_data = (count != '0);
  assign head     = mem[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && has_data;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/jse_back.sv @@
// ----------------------------------------------------------------------------
// jse_back
// Output sequencer: walks the head descriptor into the result register, one
// byte per cycle while the result register is empty or being popped.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic               clk,
  input  logic               rst,
  input  jse_pkg::desc_t     head,
  input  logic               has_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output jse_pkg::out_item_t result
);
  import jse_pkg::*;

  logic [2:0] idx;
  logic       res_valid;
  out_item_t  res;
  logic       advance;
  logic       at_end;
  logic [3:0] len;

  assign len     = desc_len(head);
  assign at_end  = ({1'b0, idx} == len - 4'd1);
  assign advance = has_data && (!res_valid || pop);
  assign q_pop   = advance && at_end;
  assign empty   = !res_valid;
  assign result  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
      idx       <= at_end ? 3'd0 : idx + 3'd1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.out_byte <= desc_byte(head, idx);
      res.out_last <= head.last && at_end;
    end
  end

endmodule

@@ sv/js_string_escaper_top.sv @@
// ----------------------------------------------------------------------------
// js_string_escaper_top
// String escaper: raw bytes in, escaped text bytes out, last flag carried.
// ----------------------------------------------------------------------------
// Bytes that pass unchanged flow at one byte per cycle while the receiver pops,
// each result passing through the descriptor queue and the result register.
// An escaped byte expands to two or six output bytes and a released prefix
// adds up to two more (at most eight per item); the output sequencer emits
// one byte per cycle while the receiver pops. Input keeps being taken while
// the descriptor queue (QUEUE_DEPTH entries) has room. A held E2 or E2 80
// produces no result until the next byte or the end of the string.
module js_string_escaper_top #(
  parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  jse_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output jse_pkg::out_item_t result
);
  import jse_pkg::*;

  desc_t q_desc;
  desc_t head;
  logic  q_push;
  logic  q_pop;
  logic  has_data;

  jse_front u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (push && !full),
    .item   (item),
    .q_push (q_push),
    .q_desc (q_desc)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_desc  (q_desc),
    .rd       (q_pop),
    .head     (head),
    .full     (full),
    .has_data (has_data)
  );

  jse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .has_data (has_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

@@ sv/jse_checker.sv @@
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks for the string escaper, bound to the top level.
// ----------------------------------------------------------------------------
module jse_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input jse_pkg::in_item_t  item,
  input logic               empty,
  input logic               pop,
  input jse_pkg::out_item_t result
);
  import jse_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before transfer");

  a_no_ctrl: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |-> (result.out_byte >= BY_CTRL))
    else $error("control byte left unescaped");

  a_item_known: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> !$isunknown(item))
    else $error("unknown bits on input transfer");

endmodule

bind js_string_escaper_top jse_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .item   (item),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

@@ sim/jse_escape_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jse_escape_checker
// Watches both queue-style channels of the string escaper. Every input transfer
// is run through a local escaping model that keeps its own held E2 / E2 80
// prefix. The model queues the escaped bytes it expects, each with its last
// flag. Every output transfer is checked field by field against the oldest
// queued byte. The running failure count and the number of bytes still
// expected go back to the testbench top.
// ----------------------------------------------------------------------------
module jse_escape_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  jse_pkg::in_item_t  item,
  input  logic               empty,
  input  logic               pop,
  input  jse_pkg::out_item_t result,
  output int                 mismatch_cnt,
  output int                 escaped_pending
);
  import jse_pkg::*;

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_LEAD,
    HELD_LEAD_MID
  } held_t;

  localparam logic [7:0] CH_UPPER_A = 8'h41;

  held_t     held = HELD_NONE;
  out_item_t escaped_q[$];
  out_item_t step_q[$];
  int        fail_cnt = 0;

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 4'd10) begin
      return CH_0 + {4'd0, n};
    end
    return CH_UPPER_A + {4'd0, n} - 8'd10;
  endfunction

  task automatic put(input logic [7:0] b);
    out_item_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic release_held();
    if (held != HELD_NONE) begin
      put(BY_LEAD);
    end
    if (held == HELD_LEAD_MID) begin
      put(BY_MID);
    end
    held = HELD_NONE;
  endtask

  task automatic escape_plain(input logic [7:0] b);
    case (b)
      CH_QUOTE: begin put(CH_BSL); put(CH_QUOTE); end
      CH_BSL:   begin put(CH_BSL); put(CH_BSL); end
      BY_BS:    begin put(CH_BSL); put(CH_B); end
      BY_FF:    begin put(CH_BSL); put(CH_F); end
      BY_LF:    begin put(CH_BSL); put(CH_N); end
      BY_CR:    begin put(CH_BSL); put(CH_R); end
      BY_TAB:   begin put(CH_BSL); put(CH_T); end
      default: begin
        if (b < BY_CTRL) begin
          put(CH_BSL);
          put(CH_U);
          put(CH_0);
          put(CH_0);
          put(hex_digit(b[7:4]));
          put(hex_digit(b[3:0]));
        end else if (b == BY_LEAD) begin
          held = HELD_LEAD;
        end else begin
          put(b);
        end
      end
    endcase
  endtask

  task automatic escape_predict(input in_item_t it);
    out_item_t tail;
    step_q.delete();
    if (held == HELD_LEAD && it.in_byte == BY_MID) begin
      held = HELD_LEAD_MID;
    end else if (held == HELD_LEAD_MID && (it.in_byte == BY_LS || it.in_byte == BY_PS)) begin
      held = HELD_NONE;
      put(CH_BSL);
      put(CH_U);
      put(CH_2);
      put(CH_0);
      put(CH_2);
      put((it.in_byte == BY_LS) ? CH_8 : CH_9);
    end else begin
      release_held();
      escape_plain(it.in_byte);
    end
    if (it.in_last) begin
      release_held();
      if (step_q.size() > 0) begin
        tail = step_q.pop_back();
        tail.out_last = 1'b1;
        step_q.push_back(tail);
      end
    end
    foreach (step_q[i]) begin
      escaped_q.push_back(step_q[i]);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      escaped_q.delete();
      held = HELD_NONE;
    end else begin
      if (pop && !empty) begin
        if (escaped_q.size() == 0) begin
          $display("%0t: unexpected output transfer, byte %h last %b",
                   $time, result.out_byte, result.out_last);
          fail_cnt++;
        end else begin
          want = escaped_q.pop_front();
          if (want.out_byte !== result.out_byte) begin
            $display("%0t: out_byte expected %h actual %h",
                     $time, want.out_byte, result.out_byte);
            fail_cnt++;
          end
          if (want.out_last !== result.out_last) begin
            $display("%0t: out_last expected %b actual %b (byte %h)",
                     $time, want.out_last, result.out_last, want.out_byte);
            fail_cnt++;
          end
        end
      end
      if (push && !full) begin
        escape_predict(item);
      end
    end
    mismatch_cnt    <= fail_cnt;
    escaped_pending <= escaped_q.size();
  end

endmodule

@@ sim/tb_js_string_escaper_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_js_string_escaper_top
// Drives strings into the escaper: a directed set of edge bytes and prefix
// cases first, then random strings mixing plain text, control bytes, quotes,
// well-formed and broken E2 80 A8/A9 sequences. The sender and the receiver
// idle at random in several phases. Checking is done by jse_escape_checker.
// ----------------------------------------------------------------------------
module tb_js_string_escaper_top;
  import jse_pkg::*;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      push  = 1'b0;
  logic      pop   = 1'b0;
  in_item_t  item  = '0;
  logic      full;
  logic      empty;
  out_item_t result;

  int mismatch_cnt;
  int escaped_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int phase_sent     = 0;

  int send_pct[4] = '{0, 74, 0, 18};
  int recv_pct[4] = '{0, 0, 74, 18};

  logic [7:0] dir_byte[25] = '{8'h00, 8'h1F, 8'h20, 8'hFF, 8'h22, 8'h5C, 8'h08, 8'h0C,
                               8'h0A, 8'h0D, 8'h09, 8'hE2, 8'h80, 8'hA8, 8'hE2, 8'h80,
                               8'hA9, 8'hE2, 8'h41, 8'hE2, 8'h80, 8'hE2, 8'h80, 8'hE2,
                               8'h01};
  logic       dir_last[25] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                               1'b1};

  always #6 clk = ~clk;

  js_string_escaper_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  jse_escape_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .item            (item),
    .empty           (empty),
    .pop             (pop),
    .result          (result),
    .mismatch_cnt    (mismatch_cnt),
    .escaped_pending (escaped_pending)
  );

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(input logic [7:0] b, input logic lst);
    in_item_t it;
    it.in_byte = b;
    it.in_last = lst;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    phase_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (escaped_pending != 0);
  endtask

  task automatic send_random_string();
    logic [7:0] str_q[$];
    int         len;
    int         pick;
    len = $urandom_range(1, 12);
    while (str_q.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 45) begin
        str_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
        str_q.push_back(8'($urandom_range(0, 8'h1F)));
      end else if (pick < 62) begin
        str_q.push_back($urandom_range(1) ? CH_QUOTE : CH_BSL);
      end else if (pick < 75) begin
        str_q.push_back(BY_LEAD);
        str_q.push_back(BY_MID);
        str_q.push_back($urandom_range(1) ? BY_LS : BY_PS);
      end else if (pick < 82) begin
        str_q.push_back(BY_LEAD);
        str_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        str_q.push_back(BY_LEAD);
        str_q.push_back(BY_MID);
        str_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        str_q.push_back(BY_LEAD);
      end else if (pick < 96) begin
        str_q.push_back(BY_LEAD);
        str_q.push_back(BY_MID);
      end else begin
        str_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
      end
    end
    foreach (str_q[i]) begin
      send_item(str_q[i], i == str_q.size() - 1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_byte[i]) begin
      send_item(dir_byte[i], dir_last[i]);
    end
    // hold off until every expected transfer is out
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      phase_sent     = 0;
      while (phase_sent < 95) begin
        send_random_string();
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && escaped_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
